FILE: hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// clocked concurrent assertions with and without reset masking
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge while reset is released
`define ASSERT_CLK_RST(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

// property checked on every rising edge, reset included
`define ASSERT_CLK(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("assertion failed");

`endif

FILE: hw/rtl/cpsc_pkg.sv
// ----------------------------------------------------------------------------
// cpsc_pkg
// shared types and constants of the charger phase switch controller
// ----------------------------------------------------------------------------
package cpsc_pkg;

  localparam int unsigned ValW     = 16;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned InTdataW  = 120;
  localparam int unsigned OutTdataW = 24;

  localparam logic [ValW-1:0] SatVal = '1;

  typedef enum logic [1:0] {
    ST_INIT  = 2'd0,
    ST_ONE   = 2'd1,
    ST_THREE = 2'd2,
    ST_WAIT  = 2'd3
  } phase_state_e;

  typedef enum logic [1:0] {
    REQ_NONE  = 2'd0,
    REQ_ONE   = 2'd1,
    REQ_TWO   = 2'd2,
    REQ_THREE = 2'd3
  } phase_req_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_ENABLED       = 3'd0,
    CFG_LIVE_LIMIT    = 3'd1,
    CFG_DEAD_LIMIT    = 3'd2,
    CFG_ZERO_LIMIT    = 3'd3,
    CFG_VOLT_SETTLE   = 3'd4,
    CFG_CURR_SETTLE   = 3'd5,
    CFG_WAIT_TIMEOUT  = 3'd6
  } cfg_idx_e;

  // reset values of the configuration registers
  localparam logic [ValW-1:0] RstLiveLimit   = 16'd200;
  localparam logic [ValW-1:0] RstDeadLimit   = 16'd15;
  localparam logic [ValW-1:0] RstZeroLimit   = 16'd0;
  localparam logic [ValW-1:0] RstVoltSettle  = 16'd120;
  localparam logic [ValW-1:0] RstCurrSettle  = 16'd120;
  localparam logic [ValW-1:0] RstWaitTimeout = 16'd600;

  typedef struct packed {
    logic            enabled;
    logic [ValW-1:0] live_voltage_limit;
    logic [ValW-1:0] dead_voltage_limit;
    logic [ValW-1:0] zero_current_limit;
    logic [ValW-1:0] voltage_settle_ticks;
    logic [ValW-1:0] current_settle_ticks;
    logic [ValW-1:0] wait_timeout_ticks;
  } cfg_t;

  // input item, last field in the lowest bits
  typedef struct packed {
    logic [ValW-1:0] backup_value;
    logic            backup_write;
    logic [1:0]      phase_request;
    logic            meter_ok;
    logic [ValW-1:0] current_c;
    logic [ValW-1:0] current_b;
    logic [ValW-1:0] current_a;
    logic [ValW-1:0] voltage_c;
    logic [ValW-1:0] voltage_b;
    logic [ValW-1:0] voltage_a;
  } item_t;

  // result item, last field in the lowest bits
  typedef struct packed {
    logic            switch_busy;
    logic            relay_on;
    logic            relay_write;
    logic [ValW-1:0] current_value;
    logic            current_write;
    phase_state_e    phase_state;
  } result_t;

  typedef struct packed {
    phase_state_e    mode_state;
    logic [1:0]      stored_request;
    logic [ValW-1:0] restore_current;
    logic [ValW-1:0] three_phase_elapsed;
    logic [ValW-1:0] one_phase_elapsed;
    logic [ValW-1:0] zero_amp_elapsed;
    logic [ValW-1:0] wait_elapsed;
    logic            has_run;
  } state_t;

  localparam int unsigned ItemW   = $bits(item_t);
  localparam int unsigned ResultW = $bits(result_t);

endpackage

FILE: hw/rtl/cpsc_cfg.sv
// ----------------------------------------------------------------------------
// cpsc_cfg
// configuration register file, write only
// ----------------------------------------------------------------------------
module cpsc_cfg
  import cpsc_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               we_i,
  input  logic [CfgIdxW-1:0] idx_i,
  input  logic [ValW-1:0]    data_i,
  output cfg_t               cfg_o
);

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (we_i) begin
      case (cfg_idx_e'(idx_i))
        CFG_ENABLED:      cfg_d.enabled              = data_i[0];
        CFG_LIVE_LIMIT:   cfg_d.live_voltage_limit   = data_i;
        CFG_DEAD_LIMIT:   cfg_d.dead_voltage_limit   = data_i;
        CFG_ZERO_LIMIT:   cfg_d.zero_current_limit   = data_i;
        CFG_VOLT_SETTLE:  cfg_d.voltage_settle_ticks = data_i;
        CFG_CURR_SETTLE:  cfg_d.current_settle_ticks = data_i;
        CFG_WAIT_TIMEOUT: cfg_d.wait_timeout_ticks   = data_i;
        default:          cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.enabled              <= 1'b1;
      cfg_q.live_voltage_limit   <= RstLiveLimit;
      cfg_q.dead_voltage_limit   <= RstDeadLimit;
      cfg_q.zero_current_limit   <= RstZeroLimit;
      cfg_q.voltage_settle_ticks <= RstVoltSettle;
      cfg_q.current_settle_ticks <= RstCurrSettle;
      cfg_q.wait_timeout_ticks   <= RstWaitTimeout;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

FILE: hw/rtl/cpsc_eval.sv
// ----------------------------------------------------------------------------
// cpsc_eval
// one evaluation tick: next controller state and result from one item
// ----------------------------------------------------------------------------
module cpsc_eval
  import cpsc_pkg::*;
(
  input  item_t   item_i,
  input  state_t  state_i,
  input  cfg_t    cfg_i,
  output state_t  state_o,
  output result_t result_o
);

  function automatic logic [ValW-1:0] bump(input logic [ValW-1:0] v);
    return (v == SatVal) ? v : v + 1'b1;
  endfunction

  logic [ValW-1:0] tp_inc, op_inc, za_inc, we_inc;
  logic [1:0]      req_nxt;
  logic [ValW-1:0] rc_nxt;
  logic            p3, p1, zero_amp, found3, found1;

  assign tp_inc = bump(state_i.three_phase_elapsed);
  assign op_inc = bump(state_i.one_phase_elapsed);
  assign za_inc = bump(state_i.zero_amp_elapsed);
  assign we_inc = bump(state_i.wait_elapsed);

  assign req_nxt = (item_i.phase_request == REQ_ONE || item_i.phase_request == REQ_THREE)
                 ? item_i.phase_request : state_i.stored_request;
  assign rc_nxt  = item_i.backup_write ? item_i.backup_value : state_i.restore_current;

  // voltage patterns, invalid meter reading counts as absent
  assign p3 = item_i.meter_ok
           && (item_i.voltage_a > cfg_i.live_voltage_limit)
           && (item_i.voltage_b > cfg_i.live_voltage_limit)
           && (item_i.voltage_c > cfg_i.live_voltage_limit);
  assign p1 = item_i.meter_ok
           && (item_i.voltage_a > cfg_i.live_voltage_limit)
           && (item_i.voltage_b < cfg_i.dead_voltage_limit)
           && (item_i.voltage_c < cfg_i.dead_voltage_limit);
  assign zero_amp = item_i.meter_ok
           && (item_i.current_a <= cfg_i.zero_current_limit)
           && (item_i.current_b <= cfg_i.zero_current_limit)
           && (item_i.current_c <= cfg_i.zero_current_limit);

  // three phase wins over one phase
  assign found3 = p3 && (tp_inc > cfg_i.voltage_settle_ticks);
  assign found1 = !found3 && p1 && (op_inc > cfg_i.voltage_settle_ticks);

  always_comb begin
    state_o                     = state_i;
    state_o.three_phase_elapsed = tp_inc;
    state_o.one_phase_elapsed   = op_inc;
    state_o.zero_amp_elapsed    = za_inc;
    state_o.wait_elapsed        = we_inc;
    state_o.stored_request      = req_nxt;
    state_o.restore_current     = rc_nxt;
    result_o                    = '0;

    if (cfg_i.enabled) begin
      state_o.has_run = 1'b1;
      case (state_i.mode_state)
        ST_INIT: begin
          if (!p3) begin
            state_o.three_phase_elapsed = '0;
          end
          if (!found3 && !p1) begin
            state_o.one_phase_elapsed = '0;
          end
          if (found3) begin
            state_o.mode_state = ST_THREE;
          end else if (found1) begin
            state_o.mode_state = ST_ONE;
          end
          if ((found3 || found1) && rc_nxt != '0) begin
            result_o.current_write = 1'b1;
            result_o.current_value = rc_nxt;
          end
        end
        ST_ONE, ST_THREE: begin
          if ((state_i.mode_state == ST_ONE && req_nxt == REQ_THREE) ||
              (state_i.mode_state == ST_THREE && req_nxt == REQ_ONE)) begin
            // pause charging and wait for the current to drop
            result_o.current_write   = 1'b1;
            state_o.mode_state       = ST_WAIT;
            state_o.zero_amp_elapsed = '0;
            state_o.wait_elapsed     = '0;
          end
        end
        ST_WAIT: begin
          if (zero_amp) begin
            if (za_inc > cfg_i.current_settle_ticks) begin
              if (req_nxt == REQ_ONE) begin
                result_o.relay_write = 1'b1;
              end
              if (req_nxt == REQ_THREE) begin
                result_o.relay_write = 1'b1;
                result_o.relay_on    = 1'b1;
              end
              state_o.mode_state          = ST_INIT;
              state_o.one_phase_elapsed   = '0;
              state_o.three_phase_elapsed = '0;
            end
          end else begin
            state_o.zero_amp_elapsed = '0;
          end
          // timeout aborts, relay command of this tick is kept
          if (we_inc > cfg_i.wait_timeout_ticks) begin
            state_o.mode_state          = ST_INIT;
            state_o.one_phase_elapsed   = '0;
            state_o.three_phase_elapsed = '0;
          end
        end
        default: state_o.mode_state = ST_INIT;
      endcase
    end

    result_o.phase_state = state_o.mode_state;
    result_o.switch_busy = state_o.has_run &&
                           (state_o.mode_state == ST_INIT || state_o.mode_state == ST_WAIT);
  end

endmodule

FILE: hw/rtl/charger_phase_switch_controller.sv
// ----------------------------------------------------------------------------
// charger_phase_switch_controller
// decides one or three phase charging and sequences the phase relay
// ----------------------------------------------------------------------------
// One input beat is one evaluation tick and gives exactly one result beat. The
// block takes a new beat every clock cycle unless back-pressure holds it. A
// beat passes the input register, then the result register; the controller
// state advances in the single cycle where the item moves between the two. Both
// registers hold their beat under back-pressure, so a stalled result stalls
// the input side only once both are full. Configuration registers must be
// written through the cfg port while no beat is in flight; the block itself
// does not enforce this. Writes take effect on the next clock edge.
module charger_phase_switch_controller
  import cpsc_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // configuration write port
  input  logic                 cfg_we_i,
  input  logic [CfgIdxW-1:0]   cfg_idx_i,
  input  logic [ValW-1:0]      cfg_data_i,
  // input ticks
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // voltage_a, voltage_b, voltage_c, current_a, current_b, current_c,
  // meter_ok, phase_request, backup_write, backup_value, zero fill
  input  logic [InTdataW-1:0]  s_axis_tdata,
  // results
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // phase_state, current_write, current_value, relay_write, relay_on,
  // switch_busy, zero fill
  output logic [OutTdataW-1:0] m_axis_tdata
);

  cfg_t    cfg;
  item_t   item_q;
  logic    in_valid_q;
  result_t res_q, res_d;
  logic    out_valid_q;
  state_t  state_q, state_d;
  logic    advance;

  cpsc_cfg u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .we_i   (cfg_we_i),
    .idx_i  (cfg_idx_i),
    .data_i (cfg_data_i),
    .cfg_o  (cfg)
  );

  cpsc_eval u_eval (
    .item_i   (item_q),
    .state_i  (state_q),
    .cfg_i    (cfg),
    .state_o  (state_d),
    .result_o (res_d)
  );

  // item moves on when the result register is free or being drained
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      item_q <= item_t'(s_axis_tdata[ItemW-1:0]);
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  // controller state, updated once per evaluated tick
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '{mode_state: ST_INIT, default: '0};
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(OutTdataW - ResultW){1'b0}}, res_q};

endmodule

FILE: hw/rtl/cpsc_checker.sv
// ----------------------------------------------------------------------------
// cpsc_checker
// port level checks of the charger phase switch controller
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cpsc_checker
  import cpsc_pkg::*;
(
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 m_axis_tvalid,
  input logic                 m_axis_tready,
  input logic [OutTdataW-1:0] m_axis_tdata
);

  result_t res;
  logic    relay_beat, relay_done, relay_on_beat, pause_beat, value_beat, stall_beat;

  assign res = result_t'(m_axis_tdata[ResultW-1:0]);

  assign relay_beat    = m_axis_tvalid && res.relay_write;
  assign relay_done    = res.phase_state == ST_INIT && res.switch_busy;
  assign relay_on_beat = m_axis_tvalid && res.relay_on;
  assign pause_beat    = m_axis_tvalid && res.current_write && res.current_value == '0;
  assign value_beat    = m_axis_tvalid && res.current_value != '0;
  assign stall_beat    = m_axis_tvalid && !m_axis_tready;

  // a relay command only comes with the return to init
  `ASSERT_CLK_RST(a_relay_in_init, clk_i, rst_ni, relay_beat |-> relay_done)

  // relay_on is zero unless the relay is commanded
  `ASSERT_CLK_RST(a_relay_on_cmd, clk_i, rst_ni, relay_on_beat |-> res.relay_write)

  // a zero current request only comes with entering wait
  `ASSERT_CLK_RST(a_pause_in_wait, clk_i, rst_ni, pause_beat |-> res.phase_state == ST_WAIT)

  // current_value is zero unless a current request is issued
  `ASSERT_CLK_RST(a_value_cmd, clk_i, rst_ni, value_beat |-> res.current_write)

  // a stalled result beat holds
  `ASSERT_CLK_RST(a_out_hold, clk_i, rst_ni, stall_beat |=> m_axis_tvalid && $stable(m_axis_tdata))

endmodule

bind charger_phase_switch_controller cpsc_checker u_cpsc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
